FILE: rtl/core/i2cbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by i2cbe_step and i2c_master_bit_engine_core.
package i2cbe_pkg;

    localparam int DELAY_W = 16;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NACK = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(357);
    localparam logic [3:0]         BITS_PER_BYTE = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_S_SDA_HI = 4'd1,
        PH_S_SCL_HI = 4'd2,
        PH_S_CHECK  = 4'd3,
        PH_S_SCL_LO = 4'd4,
        PH_BIT_L    = 4'd5,
        PH_BIT_H    = 4'd6,
        PH_BIT_F    = 4'd7,
        PH_P_LOW    = 4'd8,
        PH_P_SCL_HI = 4'd9,
        PH_P_SDA_HI = 4'd10,
        PH_P_END    = 4'd11
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [DELAY_W-1:0]   tick_count;
        logic [3:0]           bit_index;
        logic [7:0]           shift_reg;
        logic [2:0]           active_cmd;
        logic                 ack_latch;
        logic                 scl_level;
        logic                 sda_level;
        logic [7:0]           result_byte;
        logic [1:0]           status;
    } state_t;

endpackage

FILE: rtl/core/i2cbe_step.sv
// One tick of the bit engine: next state from current state and one input word.
// Purely combinational; uses i2cbe_pkg.
module i2cbe_step (
    input  i2cbe_pkg::state_t              cur,
    input  logic [i2cbe_pkg::DELAY_W-1:0]  bit_delay,
    input  logic [2:0]                     cmd,
    input  logic [7:0]                     data_byte,
    input  logic                           ack_to_send,
    input  logic                           sda_in,
    output i2cbe_pkg::state_t              nxt,
    output logic                           done
);
    import i2cbe_pkg::*;

    state_t s;
    logic   fin;

    always_comb
    begin
        s   = cur;
        fin = 1'b0;

        // commands are taken only while idle; codes above read are tick only
        if (s.phase == PH_IDLE && cmd >= CMD_START && cmd <= CMD_READ)
        begin
            s.active_cmd = cmd;
            s.ack_latch  = ack_to_send;
            s.shift_reg  = (cmd == CMD_START || cmd == CMD_WRITE) ? data_byte : 8'd0;
            s.bit_index  = 4'd0;
            s.tick_count = '0;
            if (cmd == CMD_START)
                s.phase = PH_S_SDA_HI;
            else if (cmd == CMD_STOP)
                s.phase = PH_P_LOW;
            else
                s.phase = PH_BIT_L;
        end

        if (s.phase != PH_IDLE)
        begin
            if (s.tick_count != '0)
            begin
                s.tick_count = s.tick_count - 1'b1;
            end
            else
            begin
                unique case (s.phase)
                    PH_S_SDA_HI:
                    begin
                        s.sda_level  = 1'b1;
                        s.tick_count = bit_delay;
                        s.phase      = PH_S_SCL_HI;
                    end
                    PH_S_SCL_HI:
                    begin
                        s.scl_level  = 1'b1;
                        s.tick_count = bit_delay;
                        s.phase      = PH_S_CHECK;
                    end
                    PH_S_CHECK:
                    begin
                        if (!sda_in)
                        begin
                            s.status     = ST_BUSY;
                            s.phase      = PH_IDLE;
                            s.tick_count = '0;
                            fin          = 1'b1;
                        end
                        else
                        begin
                            s.sda_level  = 1'b0;
                            s.tick_count = bit_delay;
                            s.phase      = PH_S_SCL_LO;
                        end
                    end
                    PH_S_SCL_LO:
                    begin
                        s.scl_level  = 1'b0;
                        s.tick_count = bit_delay;
                        s.bit_index  = 4'd0;
                        s.phase      = PH_BIT_L;
                    end
                    PH_BIT_L:
                    begin
                        // data bits then the ACK slot; a read releases SDA for data
                        if (s.active_cmd == CMD_READ)
                            s.sda_level = (s.bit_index < BITS_PER_BYTE) ? 1'b1 : s.ack_latch;
                        else
                            s.sda_level = (s.bit_index < BITS_PER_BYTE) ? s.shift_reg[7]
                                                                         : 1'b1;
                        s.tick_count = bit_delay >> 1;
                        s.phase      = PH_BIT_H;
                    end
                    PH_BIT_H:
                    begin
                        s.scl_level  = 1'b1;
                        s.tick_count = bit_delay;
                        s.phase      = PH_BIT_F;
                    end
                    PH_BIT_F:
                    begin
                        s.scl_level = 1'b0;
                        if (s.bit_index < BITS_PER_BYTE)
                        begin
                            s.shift_reg  = {s.shift_reg[6:0],
                                            (s.active_cmd == CMD_READ) ? sda_in : 1'b0};
                            s.bit_index  = s.bit_index + 1'b1;
                            s.tick_count = '0;
                            s.phase      = PH_BIT_L;
                        end
                        else
                        begin
                            if (s.active_cmd != CMD_READ)
                                s.ack_latch = sda_in;
                            if (s.active_cmd == CMD_READ)
                            begin
                                s.result_byte = s.shift_reg;
                                s.status      = ST_OK;
                                s.phase       = PH_IDLE;
                                s.tick_count  = '0;
                                fin           = 1'b1;
                            end
                            else if (s.active_cmd == CMD_WRITE || !s.ack_latch)
                            begin
                                s.status     = s.ack_latch ? ST_NACK : ST_OK;
                                s.phase      = PH_IDLE;
                                s.tick_count = '0;
                                fin          = 1'b1;
                            end
                            else
                            begin
                                // address NACK: close the bus with a stop
                                s.status     = ST_NACK;
                                s.phase      = PH_P_LOW;
                                s.tick_count = '0;
                            end
                        end
                    end
                    PH_P_LOW:
                    begin
                        s.sda_level  = 1'b0;
                        s.scl_level  = 1'b0;
                        s.tick_count = bit_delay;
                        s.phase      = PH_P_SCL_HI;
                    end
                    PH_P_SCL_HI:
                    begin
                        s.scl_level  = 1'b1;
                        s.tick_count = bit_delay;
                        s.phase      = PH_P_SDA_HI;
                    end
                    PH_P_SDA_HI:
                    begin
                        s.sda_level  = 1'b1;
                        s.tick_count = bit_delay;
                        s.phase      = PH_P_END;
                    end
                    PH_P_END:
                    begin
                        if (s.active_cmd == CMD_STOP)
                            s.status = ST_OK;
                        s.phase      = PH_IDLE;
                        s.tick_count = '0;
                        fin          = 1'b1;
                    end
                    default:
                    begin
                        s.phase      = PH_IDLE;
                        s.tick_count = '0;
                    end
                endcase
            end
        end
    end

    assign nxt  = s;
    assign done = fin;

endmodule

FILE: rtl/core/i2c_master_bit_engine_core.sv
// Top level of the single-master I2C bit engine: handshakes, state and result registers.
// Depends on i2cbe_pkg and i2cbe_step.
//
// Usage: every input word is one timing tick carrying cmd, data_byte, ack_to_send
// and the sampled sda_in. Each accepted word yields exactly one result word with
// the SCL/SDA drive levels, busy, done, the last read byte and status.
// Both data channels use valid/stall: a word moves when valid is high and stall
// is low. The bit delay register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high and the write takes effect on the next tick.
// Path: an accepted input word goes into the input register, then the tick update
// writes its result word into the result register.
// Throughput: one word per cycle while out_stall is low, since the whole tick update
// is a single combinational pass between the input register and the state/result registers.
// When out_stall holds, the result register keeps its word, the input register
// keeps one more, and in_stall rises only while both are full.
// Reset (rst_n low, asynchronous) puts the state register in idle with both lines
// released, status ok, read byte 0, bit delay 357 ticks; no pipeline words survive.
module i2c_master_bit_engine_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [i2cbe_pkg::DELAY_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     cmd,
    input  logic [7:0]                     data_byte,
    input  logic                           ack_to_send,
    input  logic                           sda_in,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           scl_out,
    output logic                           sda_out,
    output logic                           busy_res,
    output logic                           done_res,
    output logic [7:0]                     read_byte,
    output logic [1:0]                     status
);
    import i2cbe_pkg::*;

    logic [DELAY_W-1:0] delay_reg;

    logic       in_vld_reg;
    logic [2:0] cmd_reg;
    logic [7:0] data_reg;
    logic       ack_reg;
    logic       sda_reg;

    state_t     state_reg;
    state_t     state_next;
    logic       done_next;

    logic       out_vld_reg;
    logic       scl_reg;
    logic       sda_out_reg;
    logic       busy_reg;
    logic       done_reg;
    logic [7:0] rbyte_reg;
    logic [1:0] status_reg;

    logic       advance;
    logic       in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            delay_reg <= DELAY_RESET;
        else if (cfg_valid && cfg_ready)
            delay_reg <= cfg_data;
    end

    // result stage moves when empty or drained this cycle
    assign advance  = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (advance || !in_vld_reg)
            in_vld_reg <= in_take;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= cmd;
            data_reg <= data_byte;
            ack_reg  <= ack_to_send;
            sda_reg  <= sda_in;
        end
    end

    i2cbe_step u_step (
        .cur         (state_reg),
        .bit_delay   (delay_reg),
        .cmd         (cmd_reg),
        .data_byte   (data_reg),
        .ack_to_send (ack_reg),
        .sda_in      (sda_reg),
        .nxt         (state_next),
        .done        (done_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_IDLE;
            state_reg.tick_count  <= '0;
            state_reg.bit_index   <= 4'd0;
            state_reg.shift_reg   <= 8'd0;
            state_reg.active_cmd  <= CMD_TICK;
            state_reg.ack_latch   <= 1'b0;
            state_reg.scl_level   <= 1'b1;
            state_reg.sda_level   <= 1'b1;
            state_reg.result_byte <= 8'd0;
            state_reg.status      <= ST_OK;
        end
        else if (in_vld_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (in_vld_reg && advance)
        begin
            scl_reg     <= state_next.scl_level;
            sda_out_reg <= state_next.sda_level;
            busy_reg    <= (state_next.phase != PH_IDLE);
            done_reg    <= done_next;
            rbyte_reg   <= state_next.result_byte;
            status_reg  <= state_next.status;
        end
    end

    assign out_valid = out_vld_reg;
    assign scl_out   = scl_reg;
    assign sda_out   = sda_out_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign read_byte = rbyte_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_IDLE |-> state_reg.tick_count == '0)
        else $error("tick counter nonzero while idle");

    a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bit_index <= BITS_PER_BYTE)
        else $error("bit index past ACK slot");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && done_reg |-> !busy_reg)
        else $error("done reported while still busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.status == ST_OK || state_reg.status == ST_NACK
        || state_reg.status == ST_BUSY)
        else $error("undefined status code");
`endif

endmodule
